@@ rtl/iapt_pkg.sv @@
// Shared types and constants of the I/O access pattern tracker.
package iapt_pkg;

    // Table size and per-file span of the linear KB offset
    localparam int MAX_FILES    = 16;
    localparam int FILE_SPAN_KB = 1048576;

    // Derived widths
    localparam int SLOT_W    = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int COUNT_W   = $clog2(MAX_FILES + 1);
    localparam int SPAN_W    = 31;
    localparam int LINEAR_W  = 40;
    localparam int KB_SHIFT  = 10;

    // Command queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CLOSE  = 1'b1;

    // One incoming request
    typedef struct packed {
        logic        operation;
        logic        is_read;
        logic [31:0] length_bytes;
        logic [47:0] offset_bytes;
        logic [63:0] file_key;
    } t_req;

    // One result
    typedef struct packed {
        logic signed [39:0] offset_delta_kb;
        logic [3:0]         file_slot;
        logic               table_full;
        logic               pattern_closed;
        logic [31:0]        request_count;
        logic [31:0]        read_count;
        logic [31:0]        write_count;
        logic [47:0]        read_bytes;
        logic [47:0]        write_bytes;
        logic [47:0]        total_bytes;
        logic [4:0]         file_count;
    } t_rsp;

    // Classified command handed from front to back end
    typedef struct packed {
        logic        is_close;
        logic        is_read;
        logic [31:0] length_bytes;
        logic [47:0] offset_bytes;
        logic [63:0] file_key;
    } t_cmd;

    // Push side of the command queue
    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

endpackage

@@ rtl/iapt_front.sv @@
// Front end: holds the enable register, accepts requests and classifies them.
module iapt_front import iapt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata,
    input  logic  i_req_valid,
    output logic  o_req_stall,
    input  t_req  i_req,
    input  logic  i_queue_full,
    output t_push o_push
);

    logic r_enable;
    logic accept;

    // Hold the tracking enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    // Stall while the queue has no room
    assign o_req_stall = i_queue_full;
    assign accept      = i_req_valid && !i_queue_full;

    // Forward closes always, records only while tracking; drop the rest
    always_comb begin
        o_push.cmd.is_close     = (i_req.operation == OP_CLOSE);
        o_push.cmd.is_read      = i_req.is_read;
        o_push.cmd.length_bytes = i_req.length_bytes;
        o_push.cmd.offset_bytes = i_req.offset_bytes;
        o_push.cmd.file_key     = i_req.file_key;
        o_push.push             = accept && ((i_req.operation == OP_CLOSE) || r_enable);
    end

endmodule

@@ rtl/iapt_queue.sv @@
// Short command queue between the front and back end.
module iapt_queue import iapt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_cmd  o_head
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.push)
        else $error("push into full queue");

    // Fill count stays within the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    // A push alone raises the count by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + QCNT_W'(1)))
        else $error("queue count did not follow push");
`endif

endmodule

@@ rtl/iapt_back.sv @@
// Back end: scans the key table, updates counters and registers the result.
module iapt_back import iapt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_cmd i_head,
    output logic o_pop,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [SLOT_W-1:0]     r_idx;
    logic                  r_hit;
    logic [SLOT_W-1:0]     r_slot;
    logic [63:0]           r_keys [MAX_FILES];
    logic [COUNT_W-1:0]    r_files;
    logic [LINEAR_W-1:0]   r_prev;
    logic [31:0]           r_req_cnt;
    logic [31:0]           r_rd_cnt;
    logic [31:0]           r_wr_cnt;
    logic [47:0]           r_rd_sum;
    logic [47:0]           r_wr_sum;
    logic [47:0]           r_all_sum;
    logic                  r_rsp_valid;
    t_rsp                  r_rsp;

    logic                  out_free;
    logic                  key_match;
    logic                  scan_last;
    logic                  has_free;
    logic                  is_new;
    logic                  is_full;
    logic [SLOT_W-1:0]     slot_sel;
    logic [SLOT_W+SPAN_W-1:0] slot_base;
    logic [LINEAR_W-1:0]   linear;
    logic [LINEAR_W-1:0]   delta;
    logic [31:0]           n_req_cnt;
    logic [31:0]           n_rd_cnt;
    logic [31:0]           n_wr_cnt;
    logic [47:0]           n_rd_sum;
    logic [47:0]           n_wr_sum;
    logic [47:0]           n_all_sum;
    logic [COUNT_W-1:0]    n_files;
    logic [31:0]           slot_wide;
    logic [31:0]           files_wide;

    localparam logic [SPAN_W-1:0] SPAN = SPAN_W'(FILE_SPAN_KB);

    // Saturating increment of a count
    function automatic logic [31:0] sat_inc(input logic [31:0] a);
        return (a == '1) ? a : a + 32'd1;
    endfunction

    // Saturating add of a length into a byte sum
    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + 49'(b);
        return s[48] ? '1 : s[47:0];
    endfunction

    assign out_free  = !r_rsp_valid || !i_rsp_stall;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign key_match = (r_keys[r_idx] == r_cmd.file_key);
    assign scan_last = (COUNT_W'(r_idx) + COUNT_W'(1)) == r_files;

    // Pick the slot: hit, next free one, or none
    assign has_free = (r_files < COUNT_W'(MAX_FILES));
    assign is_new   = !r_hit && has_free;
    assign is_full  = !r_hit && !has_free;
    assign slot_sel = r_hit ? r_slot : r_files[SLOT_W-1:0];

    // Linear KB offset and its difference to the previous one
    assign slot_base = (SLOT_W+SPAN_W)'(slot_sel) * (SLOT_W+SPAN_W)'(SPAN);
    assign linear    = LINEAR_W'(slot_base) + LINEAR_W'(r_cmd.offset_bytes >> KB_SHIFT);
    assign delta     = linear - r_prev;

    // Counters after a record
    always_comb begin
        n_req_cnt = sat_inc(r_req_cnt);
        n_all_sum = sat_add(r_all_sum, r_cmd.length_bytes);
        n_rd_cnt  = r_rd_cnt;
        n_rd_sum  = r_rd_sum;
        n_wr_cnt  = r_wr_cnt;
        n_wr_sum  = r_wr_sum;
        if (r_cmd.is_read) begin
            n_rd_cnt = sat_inc(r_rd_cnt);
            n_rd_sum = sat_add(r_rd_sum, r_cmd.length_bytes);
        end else begin
            n_wr_cnt = sat_inc(r_wr_cnt);
            n_wr_sum = sat_add(r_wr_sum, r_cmd.length_bytes);
        end
        n_files    = is_new ? r_files + COUNT_W'(1) : r_files;
        slot_wide  = is_full ? 32'd0 : 32'(slot_sel);
        files_wide = r_cmd.is_close ? 32'(r_files) : 32'(n_files);
    end

    // Write a new key into its slot
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free && !r_cmd.is_close && is_new) begin
            r_keys[slot_sel] <= r_cmd.file_key;
        end
    end

    // Sequence one command; hold state, counters and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_files     <= '0;
            r_prev      <= '0;
            r_req_cnt   <= '0;
            r_rd_cnt    <= '0;
            r_wr_cnt    <= '0;
            r_rd_sum    <= '0;
            r_wr_sum    <= '0;
            r_all_sum   <= '0;
            r_rsp_valid <= 1'b0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
        end else begin
            if (r_rsp_valid && !i_rsp_stall && !((r_state == S_DONE) && out_free)) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_head;
                        r_idx <= '0;
                        r_hit <= 1'b0;
                        if (i_head.is_close || (r_files == '0)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (key_match) begin
                        r_hit   <= 1'b1;
                        r_slot  <= r_idx;
                        r_state <= S_DONE;
                    end else if (scan_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + SLOT_W'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_rsp_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_cmd.is_close) begin
                            r_rsp.offset_delta_kb <= '0;
                            r_rsp.file_slot       <= '0;
                            r_rsp.table_full      <= 1'b0;
                            r_rsp.pattern_closed  <= 1'b1;
                            r_rsp.request_count   <= r_req_cnt;
                            r_rsp.read_count      <= r_rd_cnt;
                            r_rsp.write_count     <= r_wr_cnt;
                            r_rsp.read_bytes      <= r_rd_sum;
                            r_rsp.write_bytes     <= r_wr_sum;
                            r_rsp.total_bytes     <= r_all_sum;
                            r_rsp.file_count      <= files_wide[4:0];
                            r_files   <= '0;
                            r_prev    <= '0;
                            r_req_cnt <= '0;
                            r_rd_cnt  <= '0;
                            r_wr_cnt  <= '0;
                            r_rd_sum  <= '0;
                            r_wr_sum  <= '0;
                            r_all_sum <= '0;
                        end else begin
                            r_rsp.offset_delta_kb <= is_full ? '0 : $signed(delta);
                            r_rsp.file_slot       <= slot_wide[3:0];
                            r_rsp.table_full      <= is_full;
                            r_rsp.pattern_closed  <= 1'b0;
                            r_rsp.request_count   <= n_req_cnt;
                            r_rsp.read_count      <= n_rd_cnt;
                            r_rsp.write_count     <= n_wr_cnt;
                            r_rsp.read_bytes      <= n_rd_sum;
                            r_rsp.write_bytes     <= n_wr_sum;
                            r_rsp.total_bytes     <= n_all_sum;
                            r_rsp.file_count      <= files_wide[4:0];
                            r_files   <= n_files;
                            r_req_cnt <= n_req_cnt;
                            r_rd_cnt  <= n_rd_cnt;
                            r_wr_cnt  <= n_wr_cnt;
                            r_rd_sum  <= n_rd_sum;
                            r_wr_sum  <= n_wr_sum;
                            r_all_sum <= n_all_sum;
                            if (!is_full) begin
                                r_prev <= linear;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

`ifndef NO_ASSERTIONS
    // Fill count never passes the table size
    a_files_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_files <= COUNT_W'(MAX_FILES))
        else $error("file count beyond table size");

    // The scan only visits filled slots
    a_scan_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (COUNT_W'(r_idx) < r_files))
        else $error("scan past filled slots");

    // A close empties the table
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && out_free && r_cmd.is_close) |=> (r_files == '0))
        else $error("close did not clear the table");

    // A full-table result carries no slot and no delta
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_rsp.table_full) |->
            ((r_rsp.offset_delta_kb == '0) && (r_rsp.file_slot == '0)))
        else $error("full result with slot or delta");
`endif

endmodule

@@ rtl/io_access_pattern_tracker_top.sv @@
// Top level of the I/O access pattern tracker.
//
//   channel   direction  handshake                   payload
//   request   in         i_req_valid / o_req_stall   i_req (t_req)
//   result    out        o_rsp_valid / i_rsp_stall   o_rsp (t_rsp)
//   config    in         i_cfg_we                    i_cfg_wdata (tracking enable)
//
// A record goes from the queue through a serial key scan of k slots (at most
// MAX_FILES) into the result register; a close skips the scan. The queue
// holds accepted requests until the idle back end pops the oldest one.
// Reset is synchronous; the key table has no clearing pass, the fill count
// marks which slots hold keys. Request stalls only while the queue is full;
// the result register lets the back end take the next command meanwhile.
module io_access_pattern_tracker_top import iapt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    t_push push;
    logic  queue_full;
    logic  queue_empty;
    logic  pop;
    t_cmd  head;

    // Accept and classify requests
    iapt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (i_req_valid),
        .o_req_stall  (o_req_stall),
        .i_req        (i_req),
        .i_queue_full (queue_full),
        .o_push       (push)
    );

    // Decouple front and back end
    iapt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_head  (head)
    );

    // Scan, update and report
    iapt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (queue_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

endmodule

@@ tb/iapt_stream_checker.sv @@
`timescale 1ns / 100ps
// Checker for the I/O access pattern tracker: watches both channels, predicts and compares results.
module iapt_stream_checker import iapt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    input  logic i_req_valid,
    input  logic i_req_stall,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_stall,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_hits,
    output int   o_closes
);

    localparam int KB_BYTES = 1024;
    localparam int SHOW_MAX = 40;

    // Predicted tracker state
    logic        track_en;
    logic [63:0] key_slots [MAX_FILES];
    logic        slot_used [MAX_FILES];
    logic [4:0]  files_used;
    logic [39:0] last_linear;
    logic [31:0] req_total;
    logic [31:0] rd_total;
    logic [31:0] wr_total;
    logic [47:0] rd_bytes;
    logic [47:0] wr_bytes;
    logic [47:0] all_bytes;

    // Results still owed by the block, oldest first
    t_rsp owed_rsps [$];

    function automatic logic [31:0] bump_count(logic [31:0] n);
        return (n == '1) ? n : n + 32'd1;
    endfunction

    function automatic logic [47:0] add_bytes(logic [47:0] sum, logic [31:0] len);
        logic [48:0] s;
        s = {1'b0, sum} + {17'b0, len};
        return s[48] ? '1 : s[47:0];
    endfunction

    // Copy the current counters into a result
    function automatic t_rsp with_counts(t_rsp w);
        w.request_count = req_total;
        w.read_count    = rd_total;
        w.write_count   = wr_total;
        w.read_bytes    = rd_bytes;
        w.write_bytes   = wr_bytes;
        w.total_bytes   = all_bytes;
        w.file_count    = files_used;
        return w;
    endfunction

    task automatic clear_pattern();
        for (int i = 0; i < MAX_FILES; i++) begin
            key_slots[i] = '0;
            slot_used[i] = 1'b0;
        end
        files_used  = '0;
        last_linear = '0;
        req_total   = '0;
        rd_total    = '0;
        wr_total    = '0;
        rd_bytes    = '0;
        wr_bytes    = '0;
        all_bytes   = '0;
    endtask

    // Advance the predicted state by one request; tell whether it yields a result
    task automatic track_request(input t_req r, output bit makes_rsp, output t_rsp want);
        int          hit;
        logic [39:0] linear;
        makes_rsp = 1'b1;
        want = '0;
        if (r.operation == OP_CLOSE) begin
            want = with_counts(want);
            want.pattern_closed = 1'b1;
            clear_pattern();
            return;
        end
        if (!track_en) begin
            makes_rsp = 1'b0;
            return;
        end
        req_total = bump_count(req_total);
        all_bytes = add_bytes(all_bytes, r.length_bytes);
        if (r.is_read) begin
            rd_total = bump_count(rd_total);
            rd_bytes = add_bytes(rd_bytes, r.length_bytes);
        end else begin
            wr_total = bump_count(wr_total);
            wr_bytes = add_bytes(wr_bytes, r.length_bytes);
        end
        // Look the key up, then take the first free slot
        hit = -1;
        for (int i = 0; i < MAX_FILES; i++) begin
            if (hit < 0 && slot_used[i] && key_slots[i] == r.file_key) begin
                hit = i;
            end
        end
        if (hit < 0) begin
            for (int i = 0; i < MAX_FILES; i++) begin
                if (hit < 0 && !slot_used[i]) begin
                    hit = i;
                    slot_used[i] = 1'b1;
                    key_slots[i] = r.file_key;
                    files_used = files_used + 5'd1;
                end
            end
        end
        want = with_counts(want);
        if (hit < 0) begin
            want.table_full = 1'b1;
            return;
        end
        linear = 40'(hit * FILE_SPAN_KB) + 40'(r.offset_bytes / KB_BYTES);
        want.offset_delta_kb = linear - last_linear;
        want.file_slot = hit[3:0];
        last_linear = linear;
    endtask

    task automatic report_mismatch(string what);
        o_fail_count++;
        if (o_fail_count <= SHOW_MAX) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      o_checked, name, got, want));
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_rsp want;
        bit   makes_rsp;
        if (!i_rst_n) begin
            track_en = 1'b0;
            clear_pattern();
            owed_rsps.delete();
        end else begin
            if (i_cfg_we) begin
                track_en = i_cfg_wdata;
            end
            if (i_req_valid && !i_req_stall) begin
                track_request(i_req, makes_rsp, want);
                if (makes_rsp) begin
                    owed_rsps.push_back(want);
                end
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (owed_rsps.size() == 0) begin
                    report_mismatch($sformatf("result %0h with no request owed", i_rsp));
                end else begin
                    want = owed_rsps.pop_front();
                    check_field("offset_delta_kb", 64'(i_rsp.offset_delta_kb),
                                64'(want.offset_delta_kb));
                    check_field("file_slot", i_rsp.file_slot, want.file_slot);
                    check_field("table_full", i_rsp.table_full, want.table_full);
                    check_field("pattern_closed", i_rsp.pattern_closed, want.pattern_closed);
                    check_field("request_count", i_rsp.request_count, want.request_count);
                    check_field("read_count", i_rsp.read_count, want.read_count);
                    check_field("write_count", i_rsp.write_count, want.write_count);
                    check_field("read_bytes", i_rsp.read_bytes, want.read_bytes);
                    check_field("write_bytes", i_rsp.write_bytes, want.write_bytes);
                    check_field("total_bytes", i_rsp.total_bytes, want.total_bytes);
                    check_field("file_count", i_rsp.file_count, want.file_count);
                    if (want.table_full) begin
                        o_full_hits++;
                    end
                    if (want.pattern_closed) begin
                        o_closes++;
                    end
                    o_checked++;
                end
            end
        end
        o_pending = owed_rsps.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top of the I/O access pattern tracker: clock, reset, stimulus and verdict.
module tb_top;
    import iapt_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 1750;
    localparam int POOL_MAX     = 20;
    localparam int CYCLE_LIMIT  = 8_000_000;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} t_stall_mode;

    logic clk;
    logic rst_n     = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    t_req req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    t_rsp rsp;

    int fail_count;
    int pending;
    int checked;
    int full_hits;
    int closes;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_run  = 0;
    int          cycle_count = 0;
    int          sent_count  = 0;
    logic [63:0] key_pool [POOL_MAX];
    int          pool_size = 1;

    io_access_pattern_tracker_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp)
    );

    iapt_stream_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_hits  (full_hits),
        .o_closes     (closes)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed", cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drive the result stall on the current pattern
    always @(negedge clk) begin
        case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 1);
            default: begin
                if (stall_run == 0) begin
                    rsp_stall <= ~rsp_stall;
                    stall_run = $urandom_range(1, 30);
                end else begin
                    stall_run--;
                end
            end
        endcase
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offsets mix the extremes, small values and KB boundaries
    function automatic logic [47:0] rand_offset();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 48'($urandom_range(0, 4095));
            3:       return 48'({$urandom, 10'd0}) - 48'($urandom_range(0, 1));
            default: return 48'(rand64());
        endcase
    endfunction

    function automatic logic [31:0] rand_len();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'($urandom_range(1, 65536));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req build_req(logic op, logic rd, logic [31:0] len,
                                       logic [47:0] off, logic [63:0] key);
        t_req r;
        r.operation    = op;
        r.is_read      = rd;
        r.length_bytes = len;
        r.offset_bytes = off;
        r.file_key     = key;
        return r;
    endfunction

    // Mostly pool keys, now and then a stray key
    function automatic t_req random_request(int close_odds);
        logic        op;
        logic [63:0] key;
        op  = ($urandom_range(1, close_odds) == 1) ? OP_CLOSE : OP_RECORD;
        key = ($urandom_range(0, 15) == 0) ? rand64() : key_pool[$urandom_range(0, pool_size - 1)];
        return build_req(op, 1'($urandom_range(0, 1)), rand_len(), rand_offset(), key);
    endfunction

    // Fill the key pool; some keys differ from a base in one bit only
    task automatic fill_pool(int size);
        logic [63:0] base;
        base = rand64();
        pool_size = size;
        for (int i = 0; i < size; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                key_pool[i] = base ^ (64'h1 << $urandom_range(0, 63));
            end else begin
                key_pool[i] = rand64();
            end
        end
    endtask

    // Offer one request at a falling edge, hold it until taken, then idle for the gap given
    task automatic send_item(t_req r, int gap);
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        sent_count++;
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Wait until every owed result is in, then let ignored requests drain
    task automatic wait_idle();
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_enable(logic en);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int          effective;
        int          n;
        int          burst_left;
        int          gap;
        int          gap_max;
        int          close_odds;
        logic        en;
        t_req        r;
        effective = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Tracking off after reset: record dropped, close still reports
        send_item(build_req(OP_RECORD, 1'b1, 32'd100, 48'd4096, 64'hDEAD), 1);
        send_item(build_req(OP_CLOSE, 1'b0, '0, '0, '0), 1);
        wait_idle();
        write_enable(1'b1);

        // Field extremes, forward and backward deltas
        send_item(build_req(OP_RECORD, 1'b0, '0, '0, '0), 0);
        send_item(build_req(OP_RECORD, 1'b1, '1, '1, '0), 0);
        send_item(build_req(OP_RECORD, 1'b0, '1, '0, '0), 0);
        send_item(build_req(OP_RECORD, 1'b1, 32'd1, 48'd1023, '1), 0);
        send_item(build_req(OP_RECORD, 1'b1, 32'd2, 48'd1024, '1), 0);
        // Fill the rest of the table, one key a single bit away from all ones
        for (int i = 2; i < MAX_FILES; i++) begin
            send_item(build_req(OP_RECORD, 1'(i), 32'(i * 1000), 48'(i) << 40,
                                (i == 2) ? 64'hFFFF_FFFF_FFFF_FFFE : 64'h1 << (4 * i)), 0);
        end
        // New key with the table full, then a known key, then close and reuse slot zero
        send_item(build_req(OP_RECORD, 1'b1, 32'd7, 48'd8192, 64'h1), 0);
        send_item(build_req(OP_RECORD, 1'b0, 32'd9, '1, '1), 2);
        send_item(build_req(OP_CLOSE, 1'b1, '1, '1, '1), 0);
        send_item(build_req(OP_RECORD, 1'b1, 32'd5, 48'd2048, '1), 0);
        send_item(build_req(OP_CLOSE, 1'b0, '0, '0, '0), 1);

        // Random phases with varying tracking, key pools, idling and stalls
        for (int phase = 0; effective < RANDOM_ITEMS; phase++) begin
            wait_idle();
            en = (phase % 4 != 2);
            write_enable(en);
            stall_mode = t_stall_mode'((phase + phase / 4) % 4);
            case (phase % 4)
                0:       gap_max = 0;
                1:       gap_max = 3;
                2:       gap_max = 10;
                default: gap_max = 25;
            endcase
            case ($urandom_range(0, 2))
                0:       close_odds = 6;
                1:       close_odds = 25;
                default: close_odds = 120;
            endcase
            fill_pool($urandom_range(1, POOL_MAX));
            n = en ? 250 : 60;
            burst_left = $urandom_range(1, 12);
            for (int k = 0; k < n; k++) begin
                r = random_request(close_odds);
                if (en || r.operation == OP_CLOSE) begin
                    effective++;
                end
                if (k == n - 1) begin
                    gap = 1;
                end else if (burst_left > 0) begin
                    burst_left--;
                    gap = 0;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
                end
                send_item(r, gap);
            end
        end

        wait_idle();
        $display("Sent %0d requests with tracking on and off; %0d results checked,", sent_count,
                 checked);
        $display("with %0d closes and %0d records into a full table.",
                 closes, full_hits);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
